### hw/rtl/abs_pkg.sv
package abs_pkg;

    // Width of the mask field on the input port.
    localparam int unsigned IN_MASK_W = 16;

    // Width of the count fields on the output port.
    localparam int unsigned COUNT_W = 9;

    // Action codes carried by an input beat.
    typedef enum logic [1:0] {
        ACT_CLEAR    = 2'd0,
        ACT_INSERT   = 2'd1,
        ACT_SUPERSET = 2'd2,
        ACT_MEMBER   = 2'd3
    } t_action;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_FINISH = 4'b0100,
        ST_SPARE  = 4'b1000
    } t_state;

    // Relation of one stored entry to the mask under test.
    typedef struct packed {
        logic sup;      // valid entry contains the mask
        logic sub;      // valid entry is a strict subset of the mask
        logic exact;    // valid entry equals the mask
        logic free;     // slot is free, or becomes free through removal
    } t_abs_cmp;

endpackage

### hw/rtl/abs_cmp.sv
module abs_cmp #(
    parameter int unsigned MASK_BITS = 16
) (
    input  logic [MASK_BITS-1:0] i_mask,
    input  logic [MASK_BITS-1:0] i_entry,
    input  logic                 i_entry_valid,
    output abs_pkg::t_abs_cmp    o_rel
);

    logic w_contains;
    logic w_within;
    logic w_equal;

    // Subset tests in both directions plus equality.
    assign w_contains = ((i_entry & i_mask) == i_mask);
    assign w_within   = ((i_entry & i_mask) == i_entry);
    assign w_equal    = (i_entry == i_mask);

    // Only valid entries take part; an invalid slot is free.
    always_comb begin
        o_rel.sup   = i_entry_valid && w_contains;
        o_rel.sub   = i_entry_valid && w_within && !w_equal;
        o_rel.exact = i_entry_valid && w_equal;
        o_rel.free  = !i_entry_valid || (w_within && !w_equal);
    end

endmodule

### hw/rtl/antichain_bitset_store.sv
// A clear goes from the idle state straight to the finish state, which loads the result
// beat; an insert or a query first passes through the scan state, which reads the entry
// memory through its single read port one slot per cycle into one shared compare unit.
// One item at a time: the next input beat is taken once the result is loaded into the
// output register.
// Reset (synchronous, active low) empties the table at once; no clearing pass.
module antichain_bitset_store #(
    parameter int unsigned MASK_BITS = 16,
    parameter int unsigned CAPACITY  = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_action,
    input  logic [abs_pkg::IN_MASK_W-1:0] i_set_mask,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_inserted,
    output logic                          o_found,
    output logic [abs_pkg::COUNT_W-1:0]   o_removed_count,
    output logic                          o_overflow,
    output logic [abs_pkg::COUNT_W-1:0]   o_entry_count
);

    localparam int unsigned IW  = $clog2(CAPACITY);
    localparam int unsigned CW  = $clog2(CAPACITY + 1);
    localparam int unsigned TW  = (CW > abs_pkg::COUNT_W) ? CW : abs_pkg::COUNT_W;
    localparam int unsigned LB  = (MASK_BITS < abs_pkg::IN_MASK_W) ? MASK_BITS
                                                                   : abs_pkg::IN_MASK_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    abs_pkg::t_state     r_state;
    abs_pkg::t_action    r_action;
    logic [MASK_BITS-1:0] r_mask;
    logic [MASK_BITS-1:0] w_mask_in;

    logic [MASK_BITS-1:0] r_mem [CAPACITY];
    logic [MASK_BITS-1:0] r_rd_data;
    logic [CAPACITY-1:0]  r_valid;
    logic [TW-1:0]        r_total;

    logic [IW-1:0] r_rd_idx;
    logic          r_issue_done;
    logic [IW-1:0] r_cmp_idx;
    logic          r_cmp_vld;
    logic          r_cmp_last;

    logic          r_sup;
    logic          r_exact;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic [TW-1:0] r_removed;

    logic          w_do_insert;
    logic          w_out_free;
    logic          w_accept;

    abs_pkg::t_abs_cmp w_rel;

    // Bring the port mask to the universe width.
    always_comb begin
        w_mask_in = '0;
        for (int k = 0; k < LB; k++) begin
            w_mask_in[k] = i_set_mask[k];
        end
    end

    assign o_in_ready = (r_state == abs_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;

    // The insert lands when no superset is stored and a slot is free.
    assign w_do_insert = (r_action == abs_pkg::ACT_INSERT) && !r_sup && r_free_found;

    // Shared compare unit, fed from the registered memory read.
    abs_cmp #(
        .MASK_BITS (MASK_BITS)
    ) u_cmp (
        .i_mask        (r_mask),
        .i_entry       (r_rd_data),
        .i_entry_valid (r_valid[r_cmp_idx]),
        .o_rel         (w_rel)
    );

    // Entry memory: one read per slot during the scan, one write when an insert completes.
    always_ff @(posedge i_clk) begin
        if (r_state == abs_pkg::ST_SCAN && !r_issue_done) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
        if (r_state == abs_pkg::ST_FINISH && w_out_free && w_do_insert) begin
            r_mem[r_free_idx] <= r_mask;
        end
    end

    // Beat payload captured at acceptance.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= abs_pkg::t_action'(i_action);
            r_mask   <= w_mask_in;
        end
    end

    // Sequencer, scan bookkeeping, valid bits and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= abs_pkg::ST_IDLE;
            r_valid         <= '0;
            r_total         <= '0;
            r_rd_idx        <= '0;
            r_issue_done    <= 1'b0;
            r_cmp_idx       <= '0;
            r_cmp_vld       <= 1'b0;
            r_cmp_last      <= 1'b0;
            r_sup           <= 1'b0;
            r_exact         <= 1'b0;
            r_free_found    <= 1'b0;
            r_free_idx      <= '0;
            r_removed       <= '0;
            o_out_valid     <= 1'b0;
            o_inserted      <= 1'b0;
            o_found         <= 1'b0;
            o_removed_count <= '0;
            o_overflow      <= 1'b0;
            o_entry_count   <= '0;
        end else begin
            // The finish state reloads the output itself when the beat leaves.
            if (o_out_valid && i_out_ready && r_state != abs_pkg::ST_FINISH) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                abs_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_rd_idx     <= '0;
                        r_issue_done <= 1'b0;
                        r_cmp_vld    <= 1'b0;
                        r_cmp_last   <= 1'b0;
                        r_sup        <= 1'b0;
                        r_exact      <= 1'b0;
                        r_free_found <= 1'b0;
                        r_removed    <= '0;
                        if (abs_pkg::t_action'(i_action) == abs_pkg::ACT_CLEAR) begin
                            r_state <= abs_pkg::ST_FINISH;
                        end else begin
                            r_state <= abs_pkg::ST_SCAN;
                        end
                    end
                end

                abs_pkg::ST_SCAN: begin
                    // Issue one slot read per cycle.
                    r_cmp_vld <= !r_issue_done;
                    if (!r_issue_done) begin
                        r_cmp_idx  <= r_rd_idx;
                        r_cmp_last <= (r_rd_idx == LAST_IDX);
                        if (r_rd_idx == LAST_IDX) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_rd_idx <= r_rd_idx + 1'b1;
                        end
                    end

                    // Compare the slot read in the previous cycle. A stored
                    // antichain cannot hold both a superset and a strict subset of
                    // the mask, so strict subsets are dropped as they are seen.
                    if (r_cmp_vld) begin
                        if (w_rel.sup) begin
                            r_sup <= 1'b1;
                        end
                        if (w_rel.exact) begin
                            r_exact <= 1'b1;
                        end
                        if (r_action == abs_pkg::ACT_INSERT) begin
                            if (w_rel.sub) begin
                                r_valid[r_cmp_idx] <= 1'b0;
                                r_total            <= r_total - 1'b1;
                                r_removed          <= r_removed + 1'b1;
                            end
                            if (w_rel.free && !r_free_found) begin
                                r_free_found <= 1'b1;
                                r_free_idx   <= r_cmp_idx;
                            end
                        end
                        if (r_cmp_last) begin
                            r_state <= abs_pkg::ST_FINISH;
                        end
                    end
                end

                abs_pkg::ST_FINISH: begin
                    // Commit the table change and load the result beat.
                    if (w_out_free) begin
                        o_out_valid     <= 1'b1;
                        o_inserted      <= w_do_insert;
                        o_overflow      <= (r_action == abs_pkg::ACT_INSERT) && !r_sup
                                           && !r_free_found;
                        o_removed_count <= r_removed[abs_pkg::COUNT_W-1:0];
                        case (r_action)
                            abs_pkg::ACT_SUPERSET: o_found <= r_sup;
                            abs_pkg::ACT_MEMBER:   o_found <= r_exact;
                            default:               o_found <= 1'b0;
                        endcase
                        if (r_action == abs_pkg::ACT_CLEAR) begin
                            r_valid       <= '0;
                            r_total       <= '0;
                            o_entry_count <= '0;
                        end else if (w_do_insert) begin
                            r_valid[r_free_idx] <= 1'b1;
                            r_total             <= r_total + 1'b1;
                            o_entry_count       <= abs_pkg::COUNT_W'(r_total + 1'b1);
                        end else begin
                            o_entry_count <= r_total[abs_pkg::COUNT_W-1:0];
                        end
                        r_state <= abs_pkg::ST_IDLE;
                    end
                end

                default: begin
                    r_state <= abs_pkg::ST_IDLE;
                end
            endcase
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned TBL_DEPTH   = 256;
    localparam int unsigned MASK_W      = abs_pkg::IN_MASK_W;
    localparam int unsigned ITEM_TARGET = 1750;
    localparam int unsigned FILL_SPAN   = 320;
    localparam int unsigned WDOG_LIMIT  = 4000;
    localparam int unsigned TAIL_CYCLES = 2 * (TBL_DEPTH + 3);
    localparam int unsigned HINT_DEPTH  = 48;

    typedef logic [MASK_W-1:0]           t_mask;
    typedef logic [abs_pkg::COUNT_W-1:0] t_count;

    // One store operation as it goes into the input channel.
    typedef struct packed {
        abs_pkg::t_action act;
        t_mask            mask;
        bit               drain;     // hold this beat back until every result is back
    } t_store_op;

    // One result as it should come out of the output channel.
    typedef struct packed {
        bit     inserted;
        bit     found;
        t_count removed;
        bit     overflow;
        t_count count;
    } t_store_result;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    abs_pkg::t_action i_action    = abs_pkg::ACT_CLEAR;
    t_mask            i_set_mask  = '0;
    logic             i_out_ready = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic             o_inserted;
    logic             o_found;
    t_count           o_removed_count;
    logic             o_overflow;
    t_count           o_entry_count;

    antichain_bitset_store #(
        .MASK_BITS(16),
        .CAPACITY (TBL_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_set_mask     (i_set_mask),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_inserted     (o_inserted),
        .o_found        (o_found),
        .o_removed_count(o_removed_count),
        .o_overflow     (o_overflow),
        .o_entry_count  (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the antichain table.
    t_mask       tbl_mask [TBL_DEPTH];
    bit          tbl_used [TBL_DEPTH];
    int unsigned tbl_total = 0;

    t_store_op     pending_ops[$];
    t_store_result expected_results[$];
    t_store_op     cur_op;
    t_mask         hint_masks[$];
    bit            seen_mask [0:(1 << MASK_W) - 1];

    int unsigned op_total  = 0;
    int unsigned beats_in  = 0;
    int unsigned err_cnt   = 0;
    int unsigned stall_cnt = 0;
    logic        idle_on;

    // No idling at all while the middle stretch of beats goes through.
    assign idle_on = !(beats_in >= 600 && beats_in < 900);

    initial begin
        for (int i = 0; i < TBL_DEPTH; i++) begin
            tbl_mask[i] = '0;
            tbl_used[i] = 1'b0;
        end
    end

    // True when some valid entry contains the mask.
    function automatic bit has_cover(t_mask m);
        bit hit;
        hit = 1'b0;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (tbl_used[i] && (tbl_mask[i] & m) == m) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Applies one operation to the shadow table and returns the result it yields.
    function automatic t_store_result predict_store(abs_pkg::t_action act, t_mask m);
        t_store_result r;
        int unsigned   gone;
        bit            placed;
        r = '0;
        case (act)
            abs_pkg::ACT_CLEAR: begin
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    tbl_used[i] = 1'b0;
                end
                tbl_total = 0;
            end
            abs_pkg::ACT_INSERT: begin
                if (!has_cover(m)) begin
                    // Drop every stored subset first, then take the lowest free slot.
                    gone = 0;
                    for (int i = 0; i < TBL_DEPTH; i++) begin
                        if (tbl_used[i] && (m & tbl_mask[i]) == tbl_mask[i]) begin
                            tbl_used[i] = 1'b0;
                            gone++;
                        end
                    end
                    tbl_total = tbl_total - gone;
                    placed = 1'b0;
                    for (int i = 0; i < TBL_DEPTH; i++) begin
                        if (!placed && !tbl_used[i]) begin
                            tbl_used[i] = 1'b1;
                            tbl_mask[i] = m;
                            tbl_total++;
                            placed = 1'b1;
                        end
                    end
                    r.inserted = placed;
                    r.overflow = !placed;
                    r.removed  = t_count'(gone);
                end
            end
            abs_pkg::ACT_SUPERSET: begin
                r.found = has_cover(m);
            end
            default: begin
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    if (tbl_used[i] && tbl_mask[i] == m) begin
                        r.found = 1'b1;
                    end
                end
            end
        endcase
        r.count = t_count'(tbl_total);
        return r;
    endfunction

    // Unknown bits on the output count as a mismatch.
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // Queues one operation and keeps a short list of recently inserted masks.
    task automatic push_op(abs_pkg::t_action act, t_mask m, bit drain);
        t_store_op op;
        op.act   = act;
        op.mask  = m;
        op.drain = drain;
        pending_ops.push_back(op);
        op_total++;
        if (act == abs_pkg::ACT_CLEAR) begin
            hint_masks.delete();
        end else if (act == abs_pkg::ACT_INSERT) begin
            hint_masks.push_back(m);
            if (hint_masks.size() > HINT_DEPTH) begin
                void'(hint_masks.pop_front());
            end
        end
    endtask

    // Random mask with exactly k elements.
    function automatic t_mask mask_of_weight(int unsigned k);
        t_mask m;
        m = '0;
        while ($countones(m) < k) begin
            m[$urandom_range(MASK_W - 1, 0)] = 1'b1;
        end
        return m;
    endfunction

    // Mask for mixed traffic: plain random, sparse, dense, extremes, or near a stored mask.
    function automatic t_mask pick_mask();
        t_mask m;
        int unsigned style;
        style = $urandom_range(7, 0);
        m = t_mask'($urandom);
        if (hint_masks.size() != 0 && style >= 3 && style <= 5) begin
            m = hint_masks[$urandom_range(hint_masks.size() - 1, 0)];
        end
        case (style)
            1: m = t_mask'($urandom & $urandom & $urandom);
            2: m = t_mask'($urandom | $urandom | $urandom);
            4: m[$urandom_range(MASK_W - 1, 0)] = 1'b0;
            5: m[$urandom_range(MASK_W - 1, 0)] = 1'b1;
            6: m = '0;
            7: m = '1;
            default: ;
        endcase
        return m;
    endfunction

    // Fills the table with incomparable masks of one weight, then pushes on the full table.
    task automatic fill_phase();
        int unsigned k;
        int unsigned n;
        t_mask       m;
        k = $urandom_range(12, 4);
        n = 0;
        for (int i = 0; i < (1 << MASK_W); i++) begin
            seen_mask[i] = 1'b0;
        end
        push_op(abs_pkg::ACT_CLEAR, t_mask'($urandom), 1'b1);
        while (n < TBL_DEPTH + 2) begin
            m = mask_of_weight(k);
            if (!seen_mask[m]) begin
                seen_mask[m] = 1'b1;
                push_op(abs_pkg::ACT_INSERT, m, 1'b0);
                n++;
            end
            if ($urandom_range(9, 0) == 0) begin
                push_op(abs_pkg::t_action'($urandom_range(3, 2)), pick_mask(), 1'b0);
            end
        end
        if ($urandom_range(1, 0) == 1) begin
            push_op(abs_pkg::ACT_INSERT, '1, 1'b0);
        end
        repeat (6) begin
            push_op(abs_pkg::ACT_INSERT, mask_of_weight($urandom_range(k + 1, k - 1)), 1'b0);
        end
        push_op(abs_pkg::ACT_MEMBER, pick_mask(), 1'b0);
        push_op(abs_pkg::ACT_SUPERSET, pick_mask(), 1'b0);
    endtask

    // Mixed traffic biased toward inserts and queries near stored masks.
    task automatic mixed_phase();
        int unsigned len;
        int unsigned r;
        len = $urandom_range(60, 30);
        push_op(abs_pkg::ACT_SUPERSET, pick_mask(), 1'b1);
        for (int j = 0; j < len; j++) begin
            r = $urandom_range(99, 0);
            if (r < 4) begin
                push_op(abs_pkg::ACT_CLEAR, t_mask'($urandom), 1'b0);
            end else if (r < 50) begin
                push_op(abs_pkg::ACT_INSERT, pick_mask(), 1'b0);
            end else if (r < 75) begin
                push_op(abs_pkg::ACT_SUPERSET, pick_mask(), 1'b0);
            end else if (r < 95) begin
                push_op(abs_pkg::ACT_MEMBER, pick_mask(), 1'b0);
            end else begin
                push_op(abs_pkg::t_action'($urandom_range(3, 0)), t_mask'($urandom), 1'b0);
            end
        end
    endtask

    // Reset, stimulus, and the end of the run.
    initial begin
        int unsigned fills;
        fills = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty mask, extremes, equal and superset inserts, removals, clears.
        push_op(abs_pkg::ACT_MEMBER,   '0,       1'b0);
        push_op(abs_pkg::ACT_SUPERSET, '0,       1'b0);
        push_op(abs_pkg::ACT_INSERT,   '0,       1'b0);
        push_op(abs_pkg::ACT_INSERT,   '0,       1'b0);
        push_op(abs_pkg::ACT_MEMBER,   '0,       1'b0);
        push_op(abs_pkg::ACT_INSERT,   '1,       1'b0);
        push_op(abs_pkg::ACT_SUPERSET, 16'h1234, 1'b0);
        push_op(abs_pkg::ACT_MEMBER,   '1,       1'b0);
        push_op(abs_pkg::ACT_INSERT,   16'h00FF, 1'b0);
        push_op(abs_pkg::ACT_CLEAR,    16'h5A5A, 1'b1);
        push_op(abs_pkg::ACT_INSERT,   16'h0001, 1'b0);
        push_op(abs_pkg::ACT_INSERT,   16'h0002, 1'b0);
        push_op(abs_pkg::ACT_INSERT,   16'h0003, 1'b0);
        push_op(abs_pkg::ACT_INSERT,   16'h8000, 1'b0);
        push_op(abs_pkg::ACT_INSERT,   16'h7FFF, 1'b0);
        push_op(abs_pkg::ACT_MEMBER,   16'h0003, 1'b0);
        push_op(abs_pkg::ACT_SUPERSET, 16'h0003, 1'b0);
        push_op(abs_pkg::ACT_SUPERSET, 16'h8001, 1'b0);
        push_op(abs_pkg::ACT_MEMBER,   16'h8000, 1'b0);
        push_op(abs_pkg::ACT_INSERT,   '1,       1'b0);
        push_op(abs_pkg::ACT_CLEAR,    '1,       1'b0);
        push_op(abs_pkg::ACT_MEMBER,   '1,       1'b0);
        push_op(abs_pkg::ACT_SUPERSET, '0,       1'b0);

        // Random phases; the first one always runs the table into overflow.
        while (op_total < ITEM_TARGET) begin
            if (fills == 0 || (fills < 3 && op_total + FILL_SPAN < ITEM_TARGET
                               && $urandom_range(5, 0) == 0)) begin
                fill_phase();
                fills++;
            end else begin
                mixed_phase();
            end
        end

        while (pending_ops.size() != 0 || expected_results.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $error("results still outstanding: %0d", expected_results.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Driver: predicts each accepted beat and presents the next pending one.
    always @(posedge i_clk) begin
        t_store_result res;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                res = predict_store(cur_op.act, cur_op.mask);
                expected_results.push_back(res);
                beats_in <= beats_in + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_ops.size() != 0 && !(idle_on && $urandom_range(99, 0) < 33)
                        && !(pending_ops[0].drain && expected_results.size() != 0)) begin
                    cur_op = pending_ops.pop_front();
                    i_in_valid <= 1'b1;
                    i_action   <= cur_op.act;
                    i_set_mask <= cur_op.mask;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_store_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    err_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("inserted", want.inserted, o_inserted);
                    check_field("found", want.found, o_found);
                    check_field("removed_count", want.removed, o_removed_count);
                    check_field("overflow", want.overflow, o_overflow);
                    check_field("entry_count", want.count, o_entry_count);
                end
            end
            i_out_ready <= !(idle_on && $urandom_range(99, 0) < 33);
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cnt <= 0;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
            if (stall_cnt >= WDOG_LIMIT) begin
                $error("no beat accepted for %0d cycles", WDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
